[rtl/rfsp_pkg.sv]
// rfsp_pkg: shared widths, register indexes and controller/datapath interface types
// for the random free slot picker; no dependencies
package rfsp_pkg;

  localparam int SLOT_W    = 8;   // neighbor_slot field
  localparam int TIME_W    = 32;  // seen and current tick fields
  localparam int RND_W     = 16;  // random_value field
  localparam int SCNT_W    = 6;   // slot_count register
  localparam int WIN_W     = 16;  // seen_window register
  localparam int CHOSEN_W  = 6;   // chosen_slot field
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;  // widest register
  localparam int DIVCNT_W  = $clog2(RND_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEN_WINDOW = 1'd1;

  localparam logic [SCNT_W-1:0] SLOT_COUNT_RST  = 6'd16;
  localparam logic [WIN_W-1:0]  SEEN_WINDOW_RST = 16'd128;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic scan_load;  // copy occupancy into scan shifter
    logic cnt_step;   // count one free slot candidate
    logic div_init;   // start remainder unit
    logic div_step;   // one remainder bit
    logic scan_step;  // one rank search step
    logic out_load;   // move pick into output register, clear map
  } rfsp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;  // no candidate left in shifter
    logic free_zero;  // no free slot counted
    logic div_done;   // remainder ready
    logic hit;        // current candidate is the picked one
    logic out_free;   // output register can take a result
  } rfsp_stat_t;

endpackage

[rtl/rfsp_ctrl.sv]
// rfsp_ctrl: sequencer for load, count, remainder and rank search phases
// depends on rfsp_pkg
module rfsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_entry,
  output logic                in_ready,
  input  rfsp_pkg::rfsp_stat_t stat,
  output rfsp_pkg::rfsp_cmd_t  cmd
);
  import rfsp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_CNT  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RLD  = 3'd4;
  localparam logic [2:0] ST_SCAN = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_last_entry) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.scan_load = 1'b1;
        state_nxt     = ST_CNT;
      end
      ST_CNT: begin
        if (!stat.scan_done) begin
          cmd.cnt_step = 1'b1;
        end else if (stat.free_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_RLD;
        else cmd.div_step = 1'b1;
      end
      ST_RLD: begin
        cmd.scan_load = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit || stat.scan_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[rtl/rfsp_dp.sv]
// rfsp_dp: config registers, occupancy map, free counter, remainder unit,
// rank search and output register; depends on rfsp_pkg
module rfsp_dp #(
  parameter int SLOT_LIMIT     = 32,
  parameter int RESERVED_SLOTS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rfsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfsp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_entry_valid,
  input  logic [rfsp_pkg::SLOT_W-1:0]       in_neighbor_slot,
  input  logic [rfsp_pkg::TIME_W-1:0]       in_direct_seen_time,
  input  logic [rfsp_pkg::TIME_W-1:0]       in_indirect_seen_time,
  input  logic [rfsp_pkg::TIME_W-1:0]       in_current_time,
  input  logic                              in_last_entry,
  input  logic [rfsp_pkg::RND_W-1:0]        in_random_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rfsp_pkg::CHOSEN_W-1:0]     out_chosen_slot,
  output logic                              out_found,
  input  rfsp_pkg::rfsp_cmd_t               cmd,
  output rfsp_pkg::rfsp_stat_t              stat
);
  import rfsp_pkg::*;

  localparam int CW = $clog2(SLOT_LIMIT + 1);

  logic [SCNT_W-1:0]     slot_count_r;
  logic [WIN_W-1:0]      seen_window_r;
  logic [SLOT_LIMIT-1:0] occ_r, occ_nxt;     // bit k: slot RESERVED_SLOTS+k
  logic [SLOT_LIMIT-1:0] sh_r, sh_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [CW-1:0]         free_r, free_nxt;
  logic [CW-1:0]         rank_r, rank_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [RND_W-1:0]      dvd_r, dvd_nxt;
  logic [DIVCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [CHOSEN_W-1:0]   pos_r, pos_nxt;
  logic [CHOSEN_W-1:0]   pick_r, pick_nxt;
  logic                  hit_r, hit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHOSEN_W-1:0]   out_slot_r, out_slot_nxt;
  logic                  out_found_r, out_found_nxt;

  logic [TIME_W-1:0] age_d, age_i;
  logic              seen;
  logic [CW-1:0]     count;
  logic [CW:0]       trial;
  logic              cand_free;

  assign age_d = in_current_time - in_direct_seen_time;
  assign age_i = in_current_time - in_indirect_seen_time;
  assign seen  = (age_d < {{(TIME_W-WIN_W){1'b0}}, seen_window_r}) ||
                 (age_i < {{(TIME_W-WIN_W){1'b0}}, seen_window_r});

  // slot_count saturates at SLOT_LIMIT
  assign count = (slot_count_r > SCNT_W'(SLOT_LIMIT)) ? CW'(SLOT_LIMIT) : CW'(slot_count_r);

  assign trial     = {rem_r, dvd_r[RND_W-1]};
  assign cand_free = !sh_r[0];

  assign stat.scan_done = (left_r == '0);
  assign stat.free_zero = (free_r == '0);
  assign stat.div_done  = (dcnt_r == '0);
  assign stat.hit       = (left_r != '0) && cand_free && (rank_r == rem_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    occ_nxt       = occ_r;
    sh_nxt        = sh_r;
    left_nxt      = left_r;
    free_nxt      = free_r;
    rank_nxt      = rank_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dcnt_nxt      = dcnt_r;
    pos_nxt       = pos_r;
    pick_nxt      = pick_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;

    if (cmd.accept) begin
      for (int k = 0; k < SLOT_LIMIT; k++) begin
        if (in_entry_valid && seen && in_neighbor_slot == SLOT_W'(RESERVED_SLOTS + k))
          occ_nxt[k] = 1'b1;
      end
      if (in_last_entry) begin
        dvd_nxt  = in_random_value;
        free_nxt = '0;
        pick_nxt = '0;
        hit_nxt  = 1'b0;
      end
    end

    if (cmd.scan_load) begin
      sh_nxt   = occ_r;
      left_nxt = count;
      pos_nxt  = CHOSEN_W'(RESERVED_SLOTS);
      rank_nxt = '0;
    end

    if (cmd.cnt_step) begin
      if (cand_free) free_nxt = free_r + 1'b1;
      sh_nxt   = sh_r >> 1;
      left_nxt = left_r - 1'b1;
    end

    if (cmd.div_init) begin
      rem_nxt  = '0;
      dcnt_nxt = DIVCNT_W'(RND_W);
    end

    if (cmd.div_step) begin
      if (trial >= {1'b0, free_r}) rem_nxt = CW'(trial - {1'b0, free_r});
      else rem_nxt = CW'(trial);
      dvd_nxt  = dvd_r << 1;
      dcnt_nxt = dcnt_r - 1'b1;
    end

    if (cmd.scan_step && left_r != '0) begin
      if (stat.hit) begin
        pick_nxt = pos_r;
        hit_nxt  = 1'b1;
      end
      if (cand_free) rank_nxt = rank_r + 1'b1;
      sh_nxt   = sh_r >> 1;
      left_nxt = left_r - 1'b1;
      pos_nxt  = pos_r + 1'b1;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = pick_r;
      out_found_nxt = hit_r;
      occ_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r  <= SLOT_COUNT_RST;
      seen_window_r <= SEEN_WINDOW_RST;
      occ_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_SLOT_COUNT) slot_count_r <= cfg_wdata[SCNT_W-1:0];
      if (cfg_we && cfg_index == CFG_SEEN_WINDOW) seen_window_r <= cfg_wdata[WIN_W-1:0];
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    left_r      <= left_nxt;
    free_r      <= free_nxt;
    rank_r      <= rank_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    dcnt_r      <= dcnt_nxt;
    pos_r       <= pos_nxt;
    pick_r      <= pick_nxt;
    hit_r       <= hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_slot = out_slot_r;
  assign out_found       = out_found_r;

endmodule

[rtl/random_free_slot_picker_core.sv]
// random free slot picker: non-last items only mark the occupancy map and do not stop intake;
// a last item starts a pick over count candidate slots (ending early when none is free),
// count = min(slot_count, SLOT_LIMIT): one map bit per cycle counted,
// 16-bit restoring remainder, one bit per cycle rank search
// result sits in an output register; new items are taken while it waits
// sync active-low reset: slot_count 16, seen_window 128, map clear, output empty
// depends on rfsp_pkg, rfsp_ctrl, rfsp_dp
module random_free_slot_picker_core #(
  parameter int SLOT_LIMIT     = 32,  // 1..62
  parameter int RESERVED_SLOTS = 2    // 0..2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [rfsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfsp_pkg::CFG_W-1:0]        cfg_wdata,
  // neighbor report items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_entry_valid,
  input  logic [rfsp_pkg::SLOT_W-1:0]       in_neighbor_slot,
  input  logic [rfsp_pkg::TIME_W-1:0]       in_direct_seen_time,
  input  logic [rfsp_pkg::TIME_W-1:0]       in_indirect_seen_time,
  input  logic [rfsp_pkg::TIME_W-1:0]       in_current_time,
  input  logic                              in_last_entry,
  input  logic [rfsp_pkg::RND_W-1:0]        in_random_value,
  // pick result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rfsp_pkg::CHOSEN_W-1:0]     out_chosen_slot,
  output logic                              out_found
);
  import rfsp_pkg::*;

  // controller/datapath handshake
  rfsp_cmd_t  cmd;
  rfsp_stat_t stat;

  // sequencer: idle (taking items), load, count, remainder, reload, rank search, deliver
  rfsp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_entry (in_last_entry),
    .in_ready      (in_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // reserved slots are never stored: the map only covers the contention slots,
  // and slot numbers outside them never match a map bit
  rfsp_dp #(
    .SLOT_LIMIT     (SLOT_LIMIT),
    .RESERVED_SLOTS (RESERVED_SLOTS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_entry_valid        (in_entry_valid),
    .in_neighbor_slot      (in_neighbor_slot),
    .in_direct_seen_time   (in_direct_seen_time),
    .in_indirect_seen_time (in_indirect_seen_time),
    .in_current_time       (in_current_time),
    .in_last_entry         (in_last_entry),
    .in_random_value       (in_random_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_chosen_slot       (out_chosen_slot),
    .out_found             (out_found),
    .cmd                   (cmd),
    .stat                  (stat)
  );

endmodule

[test/random_free_slot_picker_core_tb.sv]
// random_free_slot_picker_core_tb: self-checking bench for the random free slot picker,
// a directed table of neighbor reports followed by randomized rounds under random stalls
// depends on rfsp_pkg and random_free_slot_picker_core
module random_free_slot_picker_core_tb;
  import rfsp_pkg::*;

  localparam int SLOT_LIMIT     = 32;
  localparam int RESERVED_SLOTS = 2;
  localparam int MAP_BITS       = SLOT_LIMIT + RESERVED_SLOTS;
  localparam logic [MAP_BITS-1:0] RESERVED_MASK = (MAP_BITS'(1) << RESERVED_SLOTS) - 1;

  // wait long enough for a full pick to finish, with padding
  localparam int PICK_LATENCY    = 2 * SLOT_LIMIT + 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 200;

  localparam logic [TIME_W-1:0] NOW = 32'h8000_0000;

  typedef struct packed {
    logic                entry_valid;
    logic [SLOT_W-1:0]   neighbor_slot;
    logic [TIME_W-1:0]   direct_seen_time;
    logic [TIME_W-1:0]   indirect_seen_time;
    logic [TIME_W-1:0]   current_time;
    logic                last_entry;
    logic [RND_W-1:0]    random_value;
  } report_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_slot;
    logic                found;
  } pick_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // one row of the directed table: an item (with an optional typed-in pick) or a write
  typedef struct {
    row_kind_t           kind;
    report_t             rep;
    bit                  fixed;
    pick_t               want;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]    val;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_entry_valid;
  logic [SLOT_W-1:0]    in_neighbor_slot;
  logic [TIME_W-1:0]    in_direct_seen_time;
  logic [TIME_W-1:0]    in_indirect_seen_time;
  logic [TIME_W-1:0]    in_current_time;
  logic                 in_last_entry;
  logic [RND_W-1:0]     in_random_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHOSEN_W-1:0]  out_chosen_slot;
  logic                 out_found;

  // typed-in expectation travels with the item, driven like the payload
  bit                   in_fixed;
  pick_t                in_fixed_pick;

  // predictor state: register copies and the occupancy bitmap
  logic [SCNT_W-1:0]    cfg_slot_count = SLOT_COUNT_RST;
  logic [WIN_W-1:0]     cfg_window     = SEEN_WINDOW_RST;
  logic [MAP_BITS-1:0]  occ_map        = RESERVED_MASK;

  pick_t                pending_picks[$];
  plan_row_t            directed_plan[$];

  int                   err_count     = 0;
  int                   items_sent    = 0;
  int                   random_items  = 0;
  int                   picks_checked = 0;
  int                   picks_empty   = 0;
  int                   reg_writes    = 0;
  int                   holds_done    = 0;
  int                   idle_cycles   = 0;
  bit                   steady_phase  = 1'b0;
  bit                   hold_request  = 1'b0;
  int unsigned          sink_gap_left = 0;

  random_free_slot_picker_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_entry_valid        (in_entry_valid),
    .in_neighbor_slot      (in_neighbor_slot),
    .in_direct_seen_time   (in_direct_seen_time),
    .in_indirect_seen_time (in_indirect_seen_time),
    .in_current_time       (in_current_time),
    .in_last_entry         (in_last_entry),
    .in_random_value       (in_random_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_chosen_slot       (out_chosen_slot),
    .out_found             (out_found)
  );

  // period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // contention slots actually in play
  function automatic int eff_slot_count();
    return (cfg_slot_count > SLOT_LIMIT) ? SLOT_LIMIT : int'(cfg_slot_count);
  endfunction

  // mark the report's slot if recently seen; on the last item pick the free slot of rank
  // random_value mod free count and clear the map back to the reserved slots
  function automatic void absorb_report(input report_t r, output bit has_pick,
                                        output pick_t p);
    logic [TIME_W-1:0] d_age;
    logic [TIME_W-1:0] i_age;
    logic [TIME_W-1:0] win;
    int cnt;
    int free_cnt;
    int target;
    int rank;
    win      = TIME_W'(cfg_window);
    d_age    = r.current_time - r.direct_seen_time;
    i_age    = r.current_time - r.indirect_seen_time;
    has_pick = r.last_entry;
    p        = '0;
    // ages wrap modulo 2^32; slots beyond the map are dropped
    if (r.entry_valid && r.neighbor_slot < MAP_BITS && (d_age < win || i_age < win))
      occ_map[r.neighbor_slot] = 1'b1;
    if (!r.last_entry) return;
    cnt      = eff_slot_count();
    free_cnt = 0;
    for (int i = RESERVED_SLOTS; i < RESERVED_SLOTS + cnt; i++)
      if (!occ_map[i]) free_cnt++;
    if (free_cnt != 0) begin
      target = int'(r.random_value) % free_cnt;
      rank   = 0;
      for (int i = RESERVED_SLOTS; i < RESERVED_SLOTS + cnt; i++) begin
        if (!occ_map[i]) begin
          if (rank == target) begin
            p.chosen_slot = CHOSEN_W'(i);
            p.found       = 1'b1;
            break;
          end
          rank++;
        end
      end
    end
    occ_map = RESERVED_MASK;
  endfunction

  function automatic report_t mk_report(int unsigned ev, int unsigned slot,
                                        logic [TIME_W-1:0] dt, logic [TIME_W-1:0] it,
                                        logic [TIME_W-1:0] now, int unsigned last,
                                        int unsigned rnd);
    report_t r;
    r.entry_valid        = (ev != 0);
    r.neighbor_slot      = SLOT_W'(slot);
    r.direct_seen_time   = dt;
    r.indirect_seen_time = it;
    r.current_time       = now;
    r.last_entry         = (last != 0);
    r.random_value       = RND_W'(rnd);
    return r;
  endfunction

  function automatic void plan_report(report_t r);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.rep   = r;
    row.fixed = 1'b0;
    row.want  = '0;
    row.idx   = '0;
    row.val   = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_pick(report_t r, int chosen, int found);
    plan_row_t row;
    row.kind             = ROW_ITEM;
    row.rep              = r;
    row.fixed            = 1'b1;
    row.want.chosen_slot = CHOSEN_W'(chosen);
    row.want.found       = (found != 0);
    row.idx              = '0;
    row.val              = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.rep   = '0;
    row.fixed = 1'b0;
    row.want  = '0;
    row.idx   = idx;
    row.val   = val;
    directed_plan.push_back(row);
  endfunction

  // directed table, starting from the reset settings (16 slots, window 128)
  function automatic void build_directed_plan();
    // empty list right after reset: all 16 free, rank 0 and rank 15
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 0), 2, 1);
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 16'hFFFF), 17, 1);
    // seen directly just now
    plan_report(mk_report(1, 2, NOW, NOW - 32'd1000, NOW, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 0), 3, 1);
    // seen indirectly one tick inside the window
    plan_report(mk_report(1, 5, NOW - 32'd5000, NOW - 32'd127, NOW, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 3), 6, 1);
    // age equal to the window, and a stamp in the future: both too old
    plan_report(mk_report(1, 2, NOW - 32'd128, NOW + 32'd1, NOW, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 0), 2, 1);
    // age wraps through zero
    plan_report(mk_report(1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd5, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, 32'd5, 1, 0), 3, 1);
    // last item that also carries a report: mark before the pick
    plan_pick(mk_report(1, 2, NOW, NOW, NOW, 1, 0), 3, 1);
    // off the map, reserved, beyond slot_count, and an empty entry: none affect the pick
    plan_report(mk_report(1, 34, NOW, NOW, NOW, 0, 0));
    plan_report(mk_report(1, 255, NOW, NOW, NOW, 0, 0));
    plan_report(mk_report(1, 1, NOW, NOW, NOW, 0, 0));
    plan_report(mk_report(1, 33, NOW, NOW, NOW, 0, 0));
    plan_report(mk_report(0, 3, NOW, NOW, NOW, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 1), 3, 1);
    // single slot taken: nothing free
    plan_write(CFG_SLOT_COUNT, 16'd1);
    plan_report(mk_report(1, 2, NOW, NOW, NOW, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 16'hFFFF), 0, 0);
    // no candidates at all
    plan_write(CFG_SLOT_COUNT, 16'd0);
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 5), 0, 0);
    // 63 (upper write bits set too) saturates to 32 slots
    plan_write(CFG_SLOT_COUNT, 16'hFFFF);
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 31), 33, 1);
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 32), 2, 1);
    // zero window never marks
    plan_write(CFG_SEEN_WINDOW, 16'd0);
    plan_write(CFG_SLOT_COUNT, 16'd16);
    plan_pick(mk_report(1, 2, NOW, NOW, NOW, 1, 0), 2, 1);
    // widest window, one tick inside and exactly on it
    plan_write(CFG_SEEN_WINDOW, 16'hFFFF);
    plan_report(mk_report(1, 2, NOW - 32'd65534, 32'd0, NOW, 0, 0));
    plan_report(mk_report(1, 3, NOW - 32'd65535, NOW - 32'd65535, NOW, 0, 0));
    plan_pick(mk_report(0, 0, 0, 0, NOW, 1, 0), 3, 1);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned sel;
    if (no_idle) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // seen stamp clustered around the window edge, with some random and future stamps
  function automatic logic [TIME_W-1:0] seen_stamp(logic [TIME_W-1:0] now);
    int unsigned w;
    int unsigned sel;
    w   = cfg_window;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return now - TIME_W'($urandom_range(0, w + w / 2 + 2));
    if (sel == 6) return now - TIME_W'(w) + TIME_W'($urandom_range(0, 1));
    if (sel == 7) return TIME_W'($urandom);
    return now + TIME_W'($urandom_range(1, 1000));
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot();
    int unsigned sel;
    int unsigned top;
    sel = $urandom_range(0, 99);
    top = eff_slot_count() + 3;
    if (top > MAP_BITS - 1) top = MAP_BITS - 1;
    if (sel < 85) return SLOT_W'($urandom_range(0, top));
    if (sel < 95) return SLOT_W'($urandom_range(0, 255));
    return SLOT_W'($urandom_range(MAP_BITS, MAP_BITS + 6));
  endfunction

  // hold valid and payload until the item is taken, then maybe idle a while
  task automatic offer_report(report_t r, bit fixed, pick_t want);
    int unsigned gap;
    in_valid              <= 1'b1;
    in_entry_valid        <= r.entry_valid;
    in_neighbor_slot      <= r.neighbor_slot;
    in_direct_seen_time   <= r.direct_seen_time;
    in_indirect_seen_time <= r.indirect_seen_time;
    in_current_time       <= r.current_time;
    in_last_entry         <= r.last_entry;
    in_random_value       <= r.random_value;
    in_fixed              <= fixed;
    in_fixed_pick         <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = pick_gap(steady_phase);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one round of reports closed by a last item; dense rounds report every candidate slot as just seen
  task automatic send_round(bit dense);
    logic [TIME_W-1:0] now;
    report_t r;
    int n;
    int sel;
    now = TIME_W'($urandom);
    if (dense) begin
      n = eff_slot_count();
      for (int i = 0; i < n; i++) begin
        r = mk_report(1, RESERVED_SLOTS + i, now, TIME_W'($urandom), now, 0, 0);
        offer_report(r, 1'b0, '0);
      end
    end else begin
      sel = $urandom_range(0, 99);
      n = (sel < 70) ? $urandom_range(0, 10) : (sel < 95) ? $urandom_range(11, 40) :
          $urandom_range(41, 80);
      for (int i = 0; i < n; i++) begin
        r = mk_report($urandom_range(0, 15) != 0, rand_slot(), seen_stamp(now),
                      seen_stamp(now), now, 0, $urandom);
        // some noise: a stray tick in the middle of a round
        if ($urandom_range(0, 9) == 0) r.current_time = TIME_W'($urandom);
        offer_report(r, 1'b0, '0);
      end
    end
    r = mk_report($urandom_range(0, 1), rand_slot(), seen_stamp(now), seen_stamp(now),
                  now, 1, $urandom);
    offer_report(r, 1'b0, '0);
    random_items += n + 1;
  endtask

  // drop valid, wait for every pick to drain, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (PICK_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SLOT_COUNT) cfg_slot_count = val[SCNT_W-1:0];
    else cfg_window = val[WIN_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // stimulus: reset, directed table, then randomized phases
  initial begin : stimulus
    int unsigned sc_val;
    int unsigned win_val;
    logic [CFG_W-1:0] wd;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    in_valid              = 1'b0;
    in_entry_valid        = 1'b0;
    in_neighbor_slot      = '0;
    in_direct_seen_time   = '0;
    in_indirect_seen_time = '0;
    in_current_time       = '0;
    in_last_entry         = 1'b0;
    in_random_value       = '0;
    in_fixed              = 1'b0;
    in_fixed_pick         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed_plan();
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(directed_plan[i].idx, directed_plan[i].val);
      end else begin
        offer_report(directed_plan[i].rep, directed_plan[i].fixed, directed_plan[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      case (ph)
        0: begin sc_val = 16; win_val = 128; end
        1: begin sc_val = 32; win_val = 65535; end
        2: begin sc_val = 1; win_val = 0; end
        3: begin sc_val = 63; win_val = 1; end
        4: begin sc_val = 0; win_val = 300; end
        5: begin sc_val = $urandom_range(1, 32); win_val = $urandom_range(0, 65535); end
        6: begin sc_val = 32; win_val = 1000; end
        default: begin
          sc_val  = $urandom_range(33, 63);
          win_val = $urandom_range(0, 65535);
        end
      endcase
      // odd phases put junk above the slot_count field
      wd = CFG_W'(sc_val);
      if (ph % 2 == 1) wd[CFG_W-1:SCNT_W] = (CFG_W-SCNT_W)'($urandom_range(0, 1023));
      write_reg(CFG_SLOT_COUNT, wd);
      write_reg(CFG_SEEN_WINDOW, CFG_W'(win_val));
      // some phases run without random gaps on either side
      steady_phase = (ph == 1 || ph == 2 || ph == 6);
      // long receiver stall while items keep coming, so the block backs up
      if (ph == 1) hold_request = 1'b1;
      while (random_items < (ph + 1) * ITEMS_PER_PHASE) send_round($urandom_range(0, 9) == 0);
    end

    settle_block();
    $display("%0d items driven, %0d picks checked (%0d with no free slot), %0d register writes",
             items_sent, picks_checked, picks_empty, reg_writes);
    $display("slot counts 0..63 and windows 0..65535 covered, %0d long output stall(s)",
             holds_done);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random gaps, steady stretches, and one long hold-off on request
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else if (sink_gap_left > 0 && !steady_phase) begin
        out_ready <= 1'b0;
        sink_gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady_phase && $urandom_range(0, 99) < 35) sink_gap_left = pick_gap(1'b0);
      end
    end
  end

  // checker: compare each taken result with the oldest pick, then predict the taken item
  always @(posedge clk) begin : scoreboard
    report_t r;
    pick_t   exp_pick;
    pick_t   got;
    bit      has_pick;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.chosen_slot = out_chosen_slot;
        got.found       = out_found;
        if (pending_picks.size() == 0) begin
          $error("unexpected result item: chosen_slot %0d, found %0d",
                 got.chosen_slot, got.found);
          err_count++;
        end else begin
          exp_pick = pending_picks.pop_front();
          if (got.chosen_slot !== exp_pick.chosen_slot) begin
            $error("chosen_slot mismatch: expected %0d, actual %0d",
                   exp_pick.chosen_slot, got.chosen_slot);
            err_count++;
          end
          if (got.found !== exp_pick.found) begin
            $error("found mismatch: expected %0d, actual %0d", exp_pick.found, got.found);
            err_count++;
          end
          picks_checked++;
          if (!exp_pick.found) picks_empty++;
        end
      end
      if (in_valid && in_ready) begin
        r.entry_valid        = in_entry_valid;
        r.neighbor_slot      = in_neighbor_slot;
        r.direct_seen_time   = in_direct_seen_time;
        r.indirect_seen_time = in_indirect_seen_time;
        r.current_time       = in_current_time;
        r.last_entry         = in_last_entry;
        r.random_value       = in_random_value;
        absorb_report(r, has_pick, exp_pick);
        // directed rows with a typed-in answer check against that instead
        if (has_pick) pending_picks.push_back(in_fixed ? in_fixed_pick : exp_pick);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/rfsp_pkg.sv
rtl/rfsp_ctrl.sv
rtl/rfsp_dp.sv
rtl/random_free_slot_picker_core.sv
test/random_free_slot_picker_core_tb.sv
